/* design/lrupr_pkg.sv */
// Package for the LRU page replacement block: item types, command types,
// sizing constants and small helpers. No dependencies.

package lrupr_pkg;

  // Sizing of the stamp table and the address split of the program counter.
  localparam int NUM_PROCS      = 16;
  localparam int PAGES_PER_PROC = 16;
  // Must be a power of two; the page number is a plain shift of the pc.
  localparam int PAGE_BYTES     = 128;

  localparam int PROC_W   = 4;
  localparam int PC_W     = 11;
  localparam int MASK_W   = 16;
  localparam int OPAGE_W  = 4;
  localparam int TICK_W   = 32;
  localparam int MAX_RESULTS = 16;

  localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);
  localparam int PC_PAGE_W  = (PC_W > PAGE_SHIFT) ? (PC_W - PAGE_SHIFT) : 1;
  localparam int PAGE_W     = (PAGES_PER_PROC > 1) ? $clog2(PAGES_PER_PROC) : 1;
  localparam int STEP_W     = PAGE_W + 1;
  localparam int MASK_IDX_W = $clog2(MASK_W);
  localparam int STAMP_DEPTH = NUM_PROCS * PAGES_PER_PROC;
  localparam int STAMP_AW    = (STAMP_DEPTH > 1) ? $clog2(STAMP_DEPTH) : 1;
  localparam int FLUSH_CNT   = (PAGES_PER_PROC < MAX_RESULTS) ? PAGES_PER_PROC : MAX_RESULTS;

  localparam int CMD_DEPTH = 2;
  localparam int CMD_PTR_W = (CMD_DEPTH > 1) ? $clog2(CMD_DEPTH) : 1;
  localparam int CMD_CNT_W = $clog2(CMD_DEPTH + 1);

  // Result action codes.
  localparam logic ACT_PAGE_IN  = 1'b0;
  localparam logic ACT_PAGE_OUT = 1'b1;

  typedef struct packed {
    logic [PROC_W-1:0] proc_index;
    logic              is_active;
    logic [PC_W-1:0]   program_counter;
    logic [MASK_W-1:0] resident_mask;
    logic              pagein_granted;
    logic              ends_sweep;
  } in_item_t;

  typedef struct packed {
    logic               action;
    logic [PROC_W-1:0]  target_proc;
    logic [OPAGE_W-1:0] target_page;
    logic               last_result;
  } out_item_t;

  typedef enum logic [1:0] {
    CMD_STAMP,
    CMD_PAGE_IN,
    CMD_VICTIM,
    CMD_FLUSH
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e         kind;
    logic [PROC_W-1:0] proc;
    logic [PAGE_W-1:0] page;
    logic [MASK_W-1:0] mask;
    logic [TICK_W-1:0] tick;
  } cmd_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_SEARCH,
    BK_EMIT,
    BK_FLUSH
  } back_state_e;

  // Pages past the mask width never count as resident.
  function automatic logic page_resident(logic [MASK_W-1:0] mask, logic [PAGE_W-1:0] page);
    logic res;
    res = 1'b0;
    if (int'(page) < MASK_W) begin
      res = mask[MASK_IDX_W'(page)];
    end
    return res;
  endfunction

  function automatic logic [STAMP_AW-1:0] stamp_addr(logic [PROC_W-1:0] proc,
                                                     logic [PAGE_W-1:0] page);
    return STAMP_AW'(STAMP_AW'(proc) * STAMP_AW'(PAGES_PER_PROC) + STAMP_AW'(page));
  endfunction

endpackage

/* design/lrupr_front.sv */
// Front end: accepts items, keeps the tick counter and turns items into
// back-end commands, dropping out-of-range ones. Depends on lrupr_pkg.

module lrupr_front import lrupr_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push,
  input  in_item_t item_i,
  input  logic     cmd_full_i,
  output logic     full,
  output logic     cmd_valid_o,
  output cmd_t     cmd_o
);

  logic [TICK_W-1:0]    tick_q, tick_d;
  logic                 accept;
  logic                 in_range;
  logic [PC_PAGE_W-1:0] pc_page;
  logic                 page_ok;
  logic [PAGE_W-1:0]    page;
  logic                 has_cmd;
  cmd_kind_e            kind;

  assign full   = cmd_full_i;
  assign accept = push && !cmd_full_i;

  assign in_range = int'(item_i.proc_index) < NUM_PROCS;
  assign pc_page  = PC_PAGE_W'(item_i.program_counter >> PAGE_SHIFT);
  assign page_ok  = int'(pc_page) < PAGES_PER_PROC;
  assign page     = PAGE_W'(pc_page);

  always_comb begin
    has_cmd = 1'b0;
    kind    = CMD_STAMP;
    priority if (!in_range) begin
      has_cmd = 1'b0;
    end else if (!item_i.is_active) begin
      has_cmd = 1'b1;
      kind    = CMD_FLUSH;
    end else if (!page_ok) begin
      has_cmd = 1'b0;
    end else if (page_resident(item_i.resident_mask, page)) begin
      has_cmd = 1'b1;
      kind    = CMD_STAMP;
    end else if (item_i.pagein_granted) begin
      has_cmd = 1'b1;
      kind    = CMD_PAGE_IN;
    end else begin
      has_cmd = 1'b1;
      kind    = CMD_VICTIM;
    end
  end

  assign cmd_valid_o = accept && has_cmd;
  assign cmd_o.kind  = kind;
  assign cmd_o.proc  = item_i.proc_index;
  assign cmd_o.page  = page;
  assign cmd_o.mask  = item_i.resident_mask;
  assign cmd_o.tick  = tick_q;

  // Advance the tick after the item that closes a sweep.
  assign tick_d = (accept && item_i.ends_sweep) ? tick_q + TICK_W'(1) : tick_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_q <= TICK_W'(1);
    end else begin
      tick_q <= tick_d;
    end
  end

endmodule

/* design/lrupr_cmd_fifo.sv */
// Short command queue between front and back end.
// Depends on lrupr_pkg.

module lrupr_cmd_fifo import lrupr_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic wr_valid_i,
  input  cmd_t wr_data_i,
  output logic full_o,
  output logic rd_valid_o,
  output cmd_t rd_data_o,
  input  logic rd_i
);

  cmd_t                 slot_q [CMD_DEPTH];
  logic [CMD_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CMD_CNT_W-1:0] cnt_q;
  logic                 do_wr, do_rd;

  assign full_o     = cnt_q == CMD_CNT_W'(CMD_DEPTH);
  assign rd_valid_o = cnt_q != '0;
  assign rd_data_o  = slot_q[rd_ptr_q];
  assign do_wr      = wr_valid_i && !full_o;
  assign do_rd      = rd_i && rd_valid_o;

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      slot_q[wr_ptr_q] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_q <= (int'(wr_ptr_q) == CMD_DEPTH - 1) ? '0 : wr_ptr_q + CMD_PTR_W'(1);
      end
      if (do_rd) begin
        rd_ptr_q <= (int'(rd_ptr_q) == CMD_DEPTH - 1) ? '0 : rd_ptr_q + CMD_PTR_W'(1);
      end
      if (do_wr && !do_rd) begin
        cnt_q <= cnt_q + CMD_CNT_W'(1);
      end else if (do_rd && !do_wr) begin
        cnt_q <= cnt_q - CMD_CNT_W'(1);
      end
    end
  end

endmodule

/* design/lrupr_back.sv */
// Back end: stamp table, victim search, page-out sweep and result register.
// Depends on lrupr_pkg.

module lrupr_back import lrupr_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      cmd_valid_i,
  input  cmd_t      cmd_i,
  output logic      cmd_rd_o,
  output logic      empty,
  input  logic      pop,
  output out_item_t result_o
);

  back_state_e state_q, state_d;

  logic [TICK_W-1:0] stamp_mem [STAMP_DEPTH];
  logic [STAMP_DEPTH-1:0] stamp_vld_q;
  logic [TICK_W-1:0] rd_stamp_q;
  logic              rd_vld_q;

  cmd_t              cur_q, cur_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic              found_q, found_d;
  logic [TICK_W-1:0] best_q, best_d;
  logic [PAGE_W-1:0] victim_q, victim_d;
  logic [PAGE_W-1:0] flush_q, flush_d;
  logic              out_valid_q;
  out_item_t         out_q;

  logic              take;
  logic              wr_en;
  logic [STAMP_AW-1:0] wr_addr;
  logic              rd_en;
  logic [STAMP_AW-1:0] rd_addr;
  logic              scan_done;
  logic              can_load;
  logic              load;
  out_item_t         res;
  logic [PAGE_W-1:0] cmp_idx;
  logic [TICK_W-1:0] cmp_age;
  logic              flush_last;

  assign take       = (state_q == BK_IDLE) && cmd_valid_i;
  assign cmd_rd_o   = take;
  assign scan_done  = step_q == STEP_W'(PAGES_PER_PROC);
  assign can_load   = !out_valid_q || pop;
  assign flush_last = flush_q == PAGE_W'(FLUSH_CNT - 1);
  assign cmp_idx    = PAGE_W'(step_q - STEP_W'(1));
  assign cmp_age    = cur_q.tick - (rd_vld_q ? rd_stamp_q : '0);

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      BK_IDLE: begin
        if (cmd_valid_i) begin
          unique case (cmd_i.kind)
            CMD_STAMP:   state_d = BK_IDLE;
            CMD_PAGE_IN: state_d = BK_EMIT;
            CMD_VICTIM:  state_d = BK_SEARCH;
            CMD_FLUSH:   state_d = BK_FLUSH;
            default:     state_d = BK_IDLE;
          endcase
        end
      end
      BK_SEARCH: begin
        if (scan_done) begin
          state_d = found_d ? BK_EMIT : BK_IDLE;
        end
      end
      BK_EMIT: begin
        if (can_load) begin
          state_d = BK_IDLE;
        end
      end
      BK_FLUSH: begin
        if (can_load && flush_last) begin
          state_d = BK_IDLE;
        end
      end
      default: state_d = BK_IDLE;
    endcase
  end

  // Datapath controls.
  always_comb begin
    cur_d    = cur_q;
    step_d   = step_q;
    found_d  = found_q;
    best_d   = best_q;
    victim_d = victim_q;
    flush_d  = flush_q;
    wr_en    = 1'b0;
    wr_addr  = stamp_addr(cmd_i.proc, cmd_i.page);
    rd_en    = 1'b0;
    rd_addr  = stamp_addr(cur_q.proc, PAGE_W'(step_q));
    load     = 1'b0;
    res.action      = ACT_PAGE_OUT;
    res.target_proc = cur_q.proc;
    res.target_page = OPAGE_W'(victim_q);
    res.last_result = 1'b1;
    unique case (state_q)
      BK_IDLE: begin
        if (cmd_valid_i) begin
          cur_d   = cmd_i;
          step_d  = '0;
          found_d = 1'b0;
          flush_d = '0;
          // Stamp the current page; a sweep leaves stamps alone.
          wr_en   = cmd_i.kind != CMD_FLUSH;
        end
      end
      BK_SEARCH: begin
        rd_en = !scan_done;
        if (step_q != '0) begin
          if (page_resident(cur_q.mask, cmp_idx) && (!found_q || cmp_age > best_q)) begin
            found_d  = 1'b1;
            best_d   = cmp_age;
            victim_d = cmp_idx;
          end
        end
        if (!scan_done) begin
          step_d = step_q + STEP_W'(1);
        end
      end
      BK_EMIT: begin
        load = can_load;
        if (cur_q.kind == CMD_PAGE_IN) begin
          res.action      = ACT_PAGE_IN;
          res.target_page = OPAGE_W'(cur_q.page);
        end
      end
      BK_FLUSH: begin
        load            = can_load;
        res.target_page = OPAGE_W'(flush_q);
        res.last_result = flush_last;
        if (can_load) begin
          flush_d = flush_q + PAGE_W'(1);
        end
      end
      default: begin
        load = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      stamp_mem[wr_addr] <= cmd_i.tick;
    end
    if (rd_en) begin
      rd_stamp_q <= stamp_mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stamp_vld_q <= '0;
      rd_vld_q    <= 1'b0;
    end else begin
      if (wr_en) begin
        stamp_vld_q[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_vld_q <= stamp_vld_q[rd_addr];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q    <= cur_d;
    best_q   <= best_d;
    victim_q <= victim_d;
    if (load) begin
      out_q <= res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      step_q      <= '0;
      found_q     <= 1'b0;
      flush_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      found_q <= found_d;
      flush_q <= flush_d;
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (pop) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign empty    = !out_valid_q;
  assign result_o = out_q;

endmodule

/* design/lru_page_replacement.sv */
// Top level of the LRU page replacement block: front end, command queue and
// back end. Depends on lrupr_pkg, lrupr_front, lrupr_cmd_fifo, lrupr_back.
//
//   channel   handshake          payload      accepted when
//   -------   ----------------   ----------   ------------------------
//   item in   push / full        item_i       push && !full
//   result    empty / pop        result_o     pop && !empty
//
// Flow: the front takes one item per cycle while the two-entry command
// queue has room. In the back end a resident-page touch stamps the page,
// a granted page-in also emits it, a refused page-in scans the 16 stamps
// of the process via the registered table read port and emits the oldest
// resident one if any; an inactive process gets 16 page-outs, one per cycle.
// Reset: the tick starts at 1 and the per-entry valid bits of the stamp
// table clear at once, so unwritten stamps read as zero; no clearing pass.
// Stalls: a held result blocks only the back end, pausing its page-outs;
// the front keeps filling the queue and raises full once it is full.

module lru_page_replacement import lrupr_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push,
  input  in_item_t  item_i,
  output logic      full,
  output logic      empty,
  input  logic      pop,
  output out_item_t result_o
);

  logic cmd_full;
  logic fe_cmd_valid;
  cmd_t fe_cmd;
  logic be_cmd_valid;
  cmd_t be_cmd;
  logic be_cmd_rd;

  // Classify items and hold the tick.
  lrupr_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .item_i      (item_i),
    .cmd_full_i  (cmd_full),
    .full        (full),
    .cmd_valid_o (fe_cmd_valid),
    .cmd_o       (fe_cmd)
  );

  // Decouple classification from the slow scan.
  lrupr_cmd_fifo u_cmd_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (fe_cmd_valid),
    .wr_data_i  (fe_cmd),
    .full_o     (cmd_full),
    .rd_valid_o (be_cmd_valid),
    .rd_data_o  (be_cmd),
    .rd_i       (be_cmd_rd)
  );

  // Stamp, search and emit.
  lrupr_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (be_cmd_valid),
    .cmd_i       (be_cmd),
    .cmd_rd_o    (be_cmd_rd),
    .empty       (empty),
    .pop         (pop),
    .result_o    (result_o)
  );

endmodule
